FILE: sv/amenv_pkg.sv
// Shared constants and types for the AM envelope detector with DC blocker.
package amenv_pkg;

   // Default sizing handed to the top level
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int ACCUM_FRAC_BITS_DEF = 16;

   // Fixed field and register widths
   localparam int ALPHA_WIDTH     = 24;
   localparam int ACC_WIDTH       = 48;
   localparam int AUDIO_WIDTH     = 18;
   localparam int RSP_TDATA_WIDTH = ((AUDIO_WIDTH + 7) / 8) * 8;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 24;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Output saturation limits
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DC_ENABLE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POLE_COEF = 8'd1;

   // Register reset values
   localparam logic                   DC_ENABLE_RESET = 1'b1;
   localparam logic [ALPHA_WIDTH-1:0] POLE_COEF_RESET = 24'd16775538;

   // Configuration seen by the back end
   typedef struct packed {
      logic                   dc_remove_enable;
      logic [ALPHA_WIDTH-1:0] pole_coef;
   } cfg_type;

   // Queue status seen by its writer and reader
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/am_envelope_dc_block_unit.sv
// The back end handles one sample at a time with a bit-serial root and a two-pass alpha
// multiply (skipped with the blocker off); it takes the next beat from the queue only when
// idle, and two beats queue between the front and back ends.
// Reset (synchronous, active high) clears the DC accumulator, empties the queue and
// output register, and loads the blocker on with alpha = 0.9999.
module am_envelope_dc_block_unit #(
   parameter int SAMPLE_WIDTH    = amenv_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACCUM_FRAC_BITS = amenv_pkg::ACCUM_FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // sample_i, sample_q, zero padding
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic                                       req_tlast,
   // audio_out, zero padding
   output logic [amenv_pkg::RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic                                       rsp_tlast,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [amenv_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [amenv_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);

   localparam int QW = 2 * SAMPLE_WIDTH + 1;
   localparam int OW = amenv_pkg::AUDIO_WIDTH;

   logic                                enable_ff;
   logic [amenv_pkg::ALPHA_WIDTH-1:0]   alpha_ff;
   amenv_pkg::cfg_type                  cfg;
   amenv_pkg::queue_status_type         q_status;
   logic                                push;
   logic [QW-1:0]                       push_data;
   logic                                pop;
   logic [QW-1:0]                       pop_data;
   logic [OW-1:0]                       audio_out;

   // Register writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = {enable_ff, alpha_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= amenv_pkg::DC_ENABLE_RESET;
         alpha_ff  <= amenv_pkg::POLE_COEF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            amenv_pkg::CSR_DC_ENABLE: enable_ff <= csr_data[0];
            amenv_pkg::CSR_POLE_COEF: alpha_ff  <= csr_data[amenv_pkg::ALPHA_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   amenv_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample_i  (req_tdata[SAMPLE_WIDTH-1:0]),
      .sample_q  (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .block_end (req_tlast),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   amenv_queue #(
      .WIDTH (QW),
      .DEPTH (amenv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   amenv_back #(
      .SAMPLE_WIDTH    (SAMPLE_WIDTH),
      .ACCUM_FRAC_BITS (ACCUM_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_status      (q_status),
      .q_data        (pop_data),
      .pop           (pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .audio_out     (audio_out),
      .block_end_out (rsp_tlast)
   );

   assign rsp_tdata = amenv_pkg::RSP_TDATA_WIDTH'(audio_out);

endmodule

FILE: sv/amenv_front.sv
// Front end: takes a sample beat, squares both components and pushes I^2 + Q^2.
module amenv_front #(
   parameter int SAMPLE_WIDTH = amenv_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [SAMPLE_WIDTH-1:0]   sample_i,
   input  logic [SAMPLE_WIDTH-1:0]   sample_q,
   input  logic                      block_end,
   input  amenv_pkg::queue_status_type q_status,
   output logic                      push,
   output logic [2*SAMPLE_WIDTH:0]   push_data
);

   localparam int SQW = 2 * SAMPLE_WIDTH;

   logic                    sq_valid_ff;
   logic                    sq_valid_in;
   logic [SQW-1:0]          isq_ff;
   logic [SQW-1:0]          qsq_ff;
   logic                    last_ff;
   logic [SAMPLE_WIDTH-1:0] abs_i;
   logic [SAMPLE_WIDTH-1:0] abs_q;
   logic [SQW-1:0]          sum_sq;
   logic                    take;

   // Magnitude of each component; the most negative value wraps to its true size
   assign abs_i = sample_i[SAMPLE_WIDTH-1] ? (~sample_i + 1'b1) : sample_i;
   assign abs_q = sample_q[SAMPLE_WIDTH-1] ? (~sample_q + 1'b1) : sample_q;

   // Advance into the queue when it has room
   assign push      = sq_valid_ff && !q_status.full;
   assign in_ready  = !sq_valid_ff || !q_status.full;
   assign take      = in_valid && in_ready;
   assign sum_sq    = isq_ff + qsq_ff;
   assign push_data = {last_ff, sum_sq};

   always_comb begin
      sq_valid_in = sq_valid_ff;
      if (take) begin
         sq_valid_in = 1'b1;
      end else if (push) begin
         sq_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sq_valid_in;
      end
      // Square the components on accept
      if (take) begin
         isq_ff  <= SQW'(abs_i) * SQW'(abs_i);
         qsq_ff  <= SQW'(abs_q) * SQW'(abs_q);
         last_ff <= block_end;
      end
   end

endmodule

FILE: sv/amenv_queue.sv
// Short register queue between the front and back ends.
module amenv_queue #(
   parameter int WIDTH = 2 * amenv_pkg::SAMPLE_WIDTH_DEF + 1,
   parameter int DEPTH = amenv_pkg::QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output amenv_pkg::queue_status_type status
);

   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff;
   logic [PTRW-1:0]  rd_ptr_ff;
   logic [CNTW-1:0]  count_ff;
   logic [CNTW-1:0]  count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CNTW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
      // Store the beat
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/amenv_back.sv
// Back end: bit-serial square root, DC blocker and the result register.
module amenv_back #(
   parameter int SAMPLE_WIDTH    = amenv_pkg::SAMPLE_WIDTH_DEF,
   parameter int ACCUM_FRAC_BITS = amenv_pkg::ACCUM_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  amenv_pkg::cfg_type                 cfg,
   input  amenv_pkg::queue_status_type        q_status,
   input  logic [2*SAMPLE_WIDTH:0]            q_data,
   output logic                               pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [amenv_pkg::AUDIO_WIDTH-1:0]  audio_out,
   output logic                               block_end_out
);

   localparam int XW    = 2 * SAMPLE_WIDTH;
   localparam int RW    = SAMPLE_WIDTH;
   localparam int REMW  = RW + 2;
   localparam int TRW   = RW + 4;
   localparam int CNTW  = $clog2(RW);
   localparam int AW    = amenv_pkg::ALPHA_WIDTH;
   localparam int ACCW  = amenv_pkg::ACC_WIDTH;
   localparam int HIW   = ACCW - AW;
   localparam int MULW  = AW + 1;
   localparam int PRODW = 2 * MULW;
   localparam int SUMW  = PRODW + 1;
   localparam int DW    = ACCW + 2;
   localparam int OW    = amenv_pkg::AUDIO_WIDTH;
   localparam int EXTW  = (RW + 1 > OW + 1) ? RW + 1 : OW + 1;

   localparam logic signed [SUMW-1:0] ACC_MAX_EXT = SUMW'({1'b0, {(ACCW-1){1'b1}}});
   localparam logic signed [SUMW-1:0] ACC_MIN_EXT = -ACC_MAX_EXT - 1;
   localparam logic signed [DW-1:0]   HALF        = DW'(1) <<< (ACCUM_FRAC_BITS - 1);
   localparam logic signed [DW-1:0]   D_MAX       = DW'(amenv_pkg::OUT_MAX);
   localparam logic signed [DW-1:0]   D_MIN       = DW'(amenv_pkg::OUT_MIN);
   localparam logic [EXTW-1:0]        MAG_MAX     = EXTW'(amenv_pkg::OUT_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_DIFF,
      ST_MAG
   } state_type;

   state_type                state_ff, state_in;
   logic [XW-1:0]            x_ff, x_in;
   logic [REMW-1:0]          rem_ff, rem_in;
   logic [RW-1:0]            root_ff, root_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic                     last_ff, last_in;
   logic signed [PRODW-1:0]  prod_ff, prod_in;
   logic [AW-1:0]            lo_part_ff, lo_part_in;
   logic signed [ACCW-1:0]   w_ff, w_in;
   logic signed [ACCW-1:0]   acc_ff, acc_in;
   logic                     out_valid_ff, out_valid_in;
   logic [OW-1:0]            audio_ff, audio_in;
   logic                     end_ff, end_in;

   logic [TRW-1:0]           rem_pre;
   logic [TRW-1:0]           trial;
   logic [TRW-1:0]           rem_diff;
   logic signed [MULW-1:0]   mul_a;
   logic signed [MULW-1:0]   mul_b;
   logic signed [PRODW-1:0]  product;
   logic signed [SUMW-1:0]   prod_ext;
   logic signed [SUMW-1:0]   lo_ext;
   logic signed [SUMW-1:0]   mag_term;
   logic signed [SUMW-1:0]   w_sum;
   logic signed [DW-1:0]     d_round;
   logic signed [DW-1:0]     d_shift;
   logic [EXTW-1:0]          mag_ext;
   logic                     out_free;

   // One root bit a cycle: bring down two radicand bits and try the next bit
   assign rem_pre  = {rem_ff, x_ff[XW-1 -: 2]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign rem_diff = rem_pre - trial;

   // Shared multiplier: alpha times the low, then the high half of the accumulator
   assign mul_a   = signed'({1'b0, cfg.pole_coef});
   assign mul_b   = (state_ff == ST_MUL_LO) ? signed'({1'b0, acc_ff[AW-1:0]})
                                            : signed'({acc_ff[ACCW-1], acc_ff[ACCW-1 -: HIW]});
   assign product = mul_a * mul_b;

   // New accumulator value before saturation
   assign prod_ext = SUMW'(prod_ff);
   assign lo_ext   = SUMW'({1'b0, lo_part_ff});
   assign mag_term = SUMW'({1'b0, root_ff}) << ACCUM_FRAC_BITS;
   assign w_sum    = prod_ext + lo_ext + mag_term;

   // Difference, rounded half up
   assign d_round = DW'(w_ff) - DW'(acc_ff) + HALF;
   assign d_shift = d_round >>> ACCUM_FRAC_BITS;

   assign mag_ext  = EXTW'(root_ff);
   assign out_free = !out_valid_ff || out_ready;

   assign pop           = (state_ff == ST_IDLE) && !q_status.empty;
   assign out_valid     = out_valid_ff;
   assign audio_out     = audio_ff;
   assign block_end_out = end_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      lo_part_in   = lo_part_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff && !out_ready;
      audio_in     = audio_ff;
      end_in       = end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Take the next squared magnitude from the queue
            if (!q_status.empty) begin
               x_in     = q_data[XW-1:0];
               last_in  = q_data[XW];
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            x_in = x_ff << 2;
            if (rem_pre >= trial) begin
               rem_in  = rem_diff[REMW-1:0];
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rem_pre[REMW-1:0];
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(RW - 1)) begin
               state_in = cfg.dc_remove_enable ? ST_MUL_LO : ST_MAG;
            end
         end
         ST_MUL_LO: begin
            prod_in  = product;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            lo_part_in = prod_ff[2*AW-1 -: AW];
            prod_in    = product;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            // Saturate the accumulator to its signed range
            if (w_sum > ACC_MAX_EXT) begin
               w_in = ACC_MAX_EXT[ACCW-1:0];
            end else if (w_sum < ACC_MIN_EXT) begin
               w_in = ACC_MIN_EXT[ACCW-1:0];
            end else begin
               w_in = w_sum[ACCW-1:0];
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            // Hold until the result register is free, then commit the state
            if (out_free) begin
               if (d_shift > D_MAX) begin
                  audio_in = D_MAX[OW-1:0];
               end else if (d_shift < D_MIN) begin
                  audio_in = D_MIN[OW-1:0];
               end else begin
                  audio_in = d_shift[OW-1:0];
               end
               end_in       = last_ff;
               out_valid_in = 1'b1;
               acc_in       = w_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_MAG: begin
            if (out_free) begin
               audio_in     = (mag_ext > MAG_MAX) ? MAG_MAX[OW-1:0] : mag_ext[OW-1:0];
               end_in       = last_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
      x_ff       <= x_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      cnt_ff     <= cnt_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      lo_part_ff <= lo_part_in;
      w_ff       <= w_in;
      audio_ff   <= audio_in;
      end_ff     <= end_in;
   end

endmodule

FILE: verif/am_envelope_dc_block_unit_tb.sv
// Self-checking testbench for the AM envelope detector with DC blocker.
`timescale 1ns / 100ps

module am_envelope_dc_block_unit_tb;
   import amenv_pkg::*;

   localparam int SW            = SAMPLE_WIDTH_DEF;
   localparam int FRAC          = ACCUM_FRAC_BITS_DEF;
   localparam int REQ_W         = ((2 * SW + 7) / 8) * 8;
   localparam int LATENCY       = SW + 8;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int HOLD_AT       = 150;
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_MAX    = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_SAMPLES = 97;

   // Index that decodes to no register
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 8'hFF;

   localparam logic [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};
   localparam logic [SW-1:0] S_ZERO = '0;

   typedef struct packed {
      logic signed [AUDIO_WIDTH-1:0] audio;
      logic                          last;
   } audio_beat_type;

   // Predicts the audio stream and checks the block's output beats against it
   class audio_scoreboard;
      logic                          dc_on;
      logic [ALPHA_WIDTH-1:0]        alpha;
      logic signed [ACC_WIDTH-1:0]   dc_state;
      audio_beat_type                audio_due[$];
      int                            checked;
      int                            failures;

      function new();
         dc_on    = DC_ENABLE_RESET;
         alpha    = POLE_COEF_RESET;
         dc_state = '0;
         checked  = 0;
         failures = 0;
      endfunction

      function void apply_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                   logic [CSR_DATA_WIDTH-1:0] value);
         case (idx)
            CSR_DC_ENABLE: dc_on = value[0];
            CSR_POLE_COEF: alpha = value[ALPHA_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // Bit-by-bit floored square root
      function longint unsigned floor_root(longint unsigned x);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = longint'(1) << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void note_sample(logic [SW-1:0] raw_i, logic [SW-1:0] raw_q, logic last);
         longint                 si, sq, w, d;
         longint unsigned        root;
         logic signed [73:0]     product;
         audio_beat_type         beat;
         si = longint'($signed(raw_i));
         sq = longint'($signed(raw_q));
         root = floor_root(longint'(si * si + sq * sq));
         if (dc_on) begin
            // alpha * w_prev floored to the accumulator's fraction bits
            product = $signed({50'd0, alpha}) *
                      $signed({{26{dc_state[ACC_WIDTH-1]}}, dc_state});
            w = longint'(product >>> ALPHA_WIDTH) + (longint'(root) << FRAC);
            if (w > (longint'(1) << (ACC_WIDTH - 1)) - 1)
               w = (longint'(1) << (ACC_WIDTH - 1)) - 1;
            else if (w < -(longint'(1) << (ACC_WIDTH - 1)))
               w = -(longint'(1) << (ACC_WIDTH - 1));
            // round halves upward, then clamp to the audio range
            d = w - longint'(dc_state);
            d = (d + (longint'(1) << (FRAC - 1))) >>> FRAC;
            if (d > OUT_MAX) d = OUT_MAX;
            else if (d < OUT_MIN) d = OUT_MIN;
            beat.audio = d[AUDIO_WIDTH-1:0];
            dc_state   = w[ACC_WIDTH-1:0];
         end else begin
            beat.audio = (root > OUT_MAX) ? AUDIO_WIDTH'(OUT_MAX) : root[AUDIO_WIDTH-1:0];
         end
         beat.last = last;
         audio_due.push_back(beat);
      endfunction

      function void check_beat(logic signed [AUDIO_WIDTH-1:0] audio, logic last);
         audio_beat_type want;
         checked++;
         if (audio_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result %0d arrived with nothing due: audio %0d last %0b",
                        checked, audio, last);
            return;
         end
         want = audio_due.pop_front();
         if (want.audio !== audio || want.last !== last) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("result %0d mismatch: expected audio %0d last %0b, %s %0d last %0b",
                        checked, want.audio, want.last, "got audio", audio, last);
         end
      endfunction

      function int pending();
         return audio_due.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic [REQ_W-1:0]             req_tdata = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic                         req_tlast = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic                         rsp_tlast;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_data = '0;

   audio_scoreboard sb;
   int  cycle_count = 0;
   int  samples_sent = 0;
   int  markers_sent = 0;
   int  settings_written = 0;
   int  burst_left = 0;
   bit  gaps_on = 1'b0;
   int  stall_pct = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   am_envelope_dc_block_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Check each output beat, then pick the next ready level
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_beat($signed(rsp_tdata[AUDIO_WIDTH-1:0]), rsp_tlast);
         if (!hold_done && sb.checked == HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_pct == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) > stall_pct);
         end
      end
   end

   // Offer one sample beat and hold it until taken; idle between bursts
   task automatic send_sample(input logic [SW-1:0] s_i, input logic [SW-1:0] s_q,
                              input logic last);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tdata  <= {s_q, s_i};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(s_i, s_q, last);
      samples_sent++;
      if (last) markers_sent++;
   endtask

   task automatic end_stream();
      req_tvalid <= 1'b0;
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.apply_register(idx, value);
      settings_written++;
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [SW-1:0] random_component();
      logic [SW-1:0] v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
         1: begin
            v = SW'($urandom_range(0, 15));
            if ($urandom_range(0, 1)) v = -v;
         end
         2: v = S_ZERO;
         default: v = SW'($urandom());
      endcase
      return v;
   endfunction

   initial begin
      logic [CSR_DATA_WIDTH-1:0] alpha_word;
      logic [CSR_DATA_WIDTH-1:0] enable_word;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: blocker on, default pole; extremes and small vectors
      send_sample(S_ZERO, S_ZERO, 1'b0);
      send_sample(S_MAX, S_MAX, 1'b0);
      send_sample(S_MIN, S_MIN, 1'b1);
      send_sample(S_MIN, S_MAX, 1'b0);
      send_sample(S_MAX, S_MIN, 1'b0);
      send_sample(16'd3, 16'd4, 1'b1);
      send_sample(16'hFFFD, 16'hFFFC, 1'b0);
      send_sample(16'd1, S_ZERO, 1'b0);
      send_sample(S_ZERO, 16'hFFFF, 1'b1);
      end_stream();
      wait_idle();

      // Pole at its top, enable written with stray upper bits, stray index ignored
      write_register(CSR_POLE_COEF, 24'hFFFFFF);
      write_register(CSR_DC_ENABLE, 24'hFFFFFF);
      write_register(CSR_UNUSED_INDEX, 24'h000000);
      csr_valid <= 1'b0;
      repeat (4) send_sample(S_MIN, S_MIN, 1'b0);
      send_sample(S_MIN, S_MIN, 1'b1);
      end_stream();
      wait_idle();

      // Drop the pole to zero so the built-up state drives the output into the low clamp
      write_register(CSR_POLE_COEF, 24'h000000);
      csr_valid <= 1'b0;
      send_sample(S_ZERO, S_ZERO, 1'b0);
      send_sample(S_ZERO, S_ZERO, 1'b1);
      end_stream();
      wait_idle();

      // Blocker off: raw magnitude, state held
      write_register(CSR_DC_ENABLE, 24'hFFFFFE);
      csr_valid <= 1'b0;
      send_sample(S_MIN, S_MIN, 1'b0);
      send_sample(16'h1234, 16'hFEDC, 1'b0);
      send_sample(S_ZERO, S_ZERO, 1'b1);
      end_stream();
      wait_idle();

      // Blocker back on from the held state
      write_register(CSR_DC_ENABLE, 24'h000001);
      write_register(CSR_POLE_COEF, POLE_COEF_RESET);
      write_register(CSR_UNUSED_INDEX, 24'h123456);
      csr_valid <= 1'b0;
      send_sample(S_ZERO, S_ZERO, 1'b0);
      send_sample(S_MIN, S_ZERO, 1'b1);
      end_stream();
      wait_idle();

      // Random phases over a spread of poles, enable levels and idling patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: alpha_word = POLE_COEF_RESET;
            1: alpha_word = 24'hFFFFFF;
            2: alpha_word = 24'h000000;
            4: alpha_word = 24'h800000;
            default: alpha_word = CSR_DATA_WIDTH'($urandom());
         endcase
         enable_word    = CSR_DATA_WIDTH'($urandom());
         enable_word[0] = (p % 3 != 2);
         write_register(CSR_DC_ENABLE, enable_word);
         write_register(CSR_POLE_COEF, alpha_word);
         csr_valid <= 1'b0;
         gaps_on    = (p != 0) && $urandom_range(0, 3) != 0;
         stall_pct  = (p == 0) ? 0 : 10 + 30 * $urandom_range(0, 2);
         burst_left = 0;
         for (int n = 0; n < PHASE_SAMPLES; n++)
            send_sample(random_component(), random_component(), $urandom_range(0, 7) == 0);
         end_stream();
         wait_idle();
      end

      // Let any stray beat surface before closing
      repeat (2 * LATENCY) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0d expected results never arrived", sb.pending());
         sb.failures += sb.pending();
      end
      $display("Covered %0d samples (%0d block ends) and %0d register writes,",
               samples_sent, markers_sent, settings_written);
      $display("with sender gaps, receiver stalls and a %0d-cycle output hold-off; %0d failures.",
               HOLD_CYCLES, sb.failures);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
